/* design/bms_pkg.sv */
`timescale 1ns / 1ps

package bms_pkg;

	// Operation codes carried on the op port.
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_WRITE = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_PLAY  = 3'd4
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SOUND
	} state_t;

	// Note code that keeps the present PWM values.
	localparam logic [2:0] NOTE_REST = 3'd7;

	// Timer prescale factor folded into the reload formula.
	localparam longint unsigned PRESCALE = 64'd320;

	// Note frequencies C5..B5 in hundredths of a hertz.
	localparam longint unsigned PITCH_CHZ [7] = '{
		64'd52325, 64'd58733, 64'd65925, 64'd69846, 64'd78399, 64'd88000, 64'd98777
	};

	// One stored melody entry.
	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] dur;
	} note_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic eval;
		logic sound;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic playing;
		logic next_note;
	} dp_stat_t;

endpackage

/* design/buzzer_melody_sequencer.sv */
`timescale 1ns / 1ps
// A word is shown in the cycle after acceptance for write, stop, single note, idle
// tick and unused codes; a start passes through the sound state, and a tick while
// playing through evaluation and, when the next note is due, the sound state (memory
// read, evaluation, and a second read when the next note sounds). Throughput: one word
// per cycle for most operations; a start and a tick while playing hold busy, set by the single read port of the store.
// Reset clears playback state and PWM values; the melody store is not cleared.
// Results are strobed for one cycle by valid and the receiver cannot stall.

module buzzer_melody_sequencer import bms_pkg::*; #(
	parameter int MAX_NOTES      = 64,
	parameter int TIMER_CLOCK_HZ = 84000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [5:0]  entry_index,
	input  logic [2:0]  note_code,
	input  logic [15:0] duration_ms,
	input  logic [6:0]  note_count,
	output logic        valid,
	output logic        playing,
	output logic [15:0] reload_value,
	output logic [15:0] compare_value,
	output logic        timer_enabled,
	output logic        sequence_done
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      dp_done;

	// Sequencing controller.
	bms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid)
	);

	// Melody store, playback counters and PWM registers.
	bms_dp #(
		.MAX_NOTES      (MAX_NOTES),
		.TIMER_CLOCK_HZ (TIMER_CLOCK_HZ)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.entry_index   (entry_index),
		.note_code     (note_code),
		.duration_ms   (duration_ms),
		.note_count    (note_count),
		.stat          (stat),
		.playing       (playing),
		.reload_value  (reload_value),
		.compare_value (compare_value),
		.timer_enabled (timer_enabled),
		.done          (dp_done)
	);

	// The done pulse is shown only with the word that carries it.
	assign sequence_done = dp_done & valid;

endmodule

/* design/bms_ctrl.sv */
`timescale 1ns / 1ps

module bms_ctrl import bms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       busy,
	output logic       valid
);

	state_t state_q, state_d;
	logic   valid_q, valid_d;

	// State and strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

	// Next state and datapath commands. A tick while playing needs the stored
	// entry, and a start or a note change needs the new entry's code, so those
	// pass through the evaluation and sound states to use the memory read port.
	always_comb begin
		state_d    = state_q;
		valid_d    = 1'b0;
		cmd.accept = 1'b0;
		cmd.eval   = 1'b0;
		cmd.sound  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					priority if (op == OP_TICK && stat.playing) begin
						state_d = ST_EVAL;
					end else if (op == OP_START) begin
						state_d = ST_SOUND;
					end else begin
						valid_d = 1'b1;
					end
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.next_note) begin
					state_d = ST_SOUND;
				end else begin
					state_d = ST_IDLE;
					valid_d = 1'b1;
				end
			end
			ST_SOUND: begin
				cmd.sound = 1'b1;
				state_d   = ST_IDLE;
				valid_d   = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign valid = valid_q;

endmodule

/* design/bms_dp.sv */
`timescale 1ns / 1ps

module bms_dp import bms_pkg::*; #(
	parameter int MAX_NOTES      = 64,
	parameter int TIMER_CLOCK_HZ = 84000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	input  logic [2:0]  op,
	input  logic [5:0]  entry_index,
	input  logic [2:0]  note_code,
	input  logic [15:0] duration_ms,
	input  logic [6:0]  note_count,
	output dp_stat_t    stat,
	output logic        playing,
	output logic [15:0] reload_value,
	output logic [15:0] compare_value,
	output logic        timer_enabled,
	output logic        done
);

	localparam int IDX_W = $clog2(MAX_NOTES);
	localparam int CNT_W = $clog2(MAX_NOTES + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
	localparam longint unsigned TICK_NUM = 64'(TIMER_CLOCK_HZ) * 64'd100;

	// Reload per note code; the last slot belongs to the rest code and is unused.
	localparam logic [15:0] RELOAD_TBL [8] = '{
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[0]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[1]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[2]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[3]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[4]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[5]) - 64'd1),
		16'(TICK_NUM / (PRESCALE * PITCH_CHZ[6]) - 64'd1),
		16'd0
	};

	note_entry_t      mem [MAX_NOTES];
	note_entry_t      rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] len_q;
	logic [15:0]      elapsed_q;
	logic             playing_q;
	logic [15:0]      reload_q;
	logic [15:0]      compare_q;
	logic             timer_q;
	logic             done_q;

	logic [15:0]      elapsed_inc;
	logic             reached;
	logic [CNT_W-1:0] idx_inc;
	logic             last;
	logic [CNT_W-1:0] len_sat;
	logic [CMP_W-1:0] count_ext;
	logic [2:0]       snd_code;
	logic             snd_hit;
	logic [15:0]      snd_reload;

	// Tick evaluation against the entry read for the current index.
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign reached     = (elapsed_inc >= rd_q.dur);
	assign idx_inc     = idx_q + CNT_W'(1);
	assign last        = (idx_inc >= len_q);

	assign stat.playing   = playing_q;
	assign stat.next_note = reached && !last;

	// Saturate the requested length to the store depth.
	assign count_ext = CMP_W'(note_count);
	assign len_sat   = (count_ext > CMP_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES) : CNT_W'(count_ext);

	// Note to sound: the stored code after a read, or the code on the port.
	assign snd_code   = cmd.sound ? rd_q.code : note_code;
	assign snd_hit    = (snd_code != NOTE_REST);
	assign snd_reload = RELOAD_TBL[snd_code];

	// Memory addressing. Entry 0 is fetched on a start, the following entry
	// during a tick evaluation, and the current entry otherwise.
	assign wr_en   = cmd.accept && (op == OP_WRITE) && (32'(entry_index) < 32'(MAX_NOTES));
	assign wr_addr = IDX_W'(entry_index);

	always_comb begin
		priority if (cmd.eval) begin
			rd_addr = idx_inc[IDX_W-1:0];
		end else if (cmd.accept && op == OP_START) begin
			rd_addr = '0;
		end else begin
			rd_addr = idx_q[IDX_W-1:0];
		end
	end

	// Melody store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{code: note_code, dur: duration_ms};
		end
		rd_q <= mem[rd_addr];
	end

	// Playback state and PWM values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			len_q     <= '0;
			elapsed_q <= '0;
			playing_q <= 1'b0;
			reload_q  <= '0;
			compare_q <= '0;
			timer_q   <= 1'b0;
			done_q    <= 1'b0;
		end else if (cmd.accept) begin
			done_q <= 1'b0;
			unique case (op_t'(op))
				OP_START: begin
					len_q     <= len_sat;
					idx_q     <= '0;
					elapsed_q <= '0;
					playing_q <= 1'b1;
					timer_q   <= 1'b1;
				end
				OP_STOP: begin
					playing_q <= 1'b0;
					compare_q <= '0;
				end
				OP_PLAY: begin
					if (snd_hit) begin
						reload_q  <= snd_reload;
						compare_q <= snd_reload >> 1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.eval) begin
			if (reached) begin
				idx_q <= idx_inc;
				if (last) begin
					playing_q <= 1'b0;
					compare_q <= '0;
					done_q    <= 1'b1;
				end else begin
					elapsed_q <= '0;
				end
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end else if (cmd.sound) begin
			if (snd_hit) begin
				reload_q  <= snd_reload;
				compare_q <= snd_reload >> 1;
			end
		end
	end

	assign playing       = playing_q;
	assign reload_value  = reload_q;
	assign compare_value = compare_q;
	assign timer_enabled = timer_q;
	assign done          = done_q;

endmodule

/* design/bms_chk.sv */
`timescale 1ns / 1ps

module bms_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        valid,
	input logic        playing,
	input logic [15:0] compare_value,
	input logic        timer_enabled,
	input logic        sequence_done
);

	// Every accepted word gets a result next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || valid)
		else $error("accepted word neither produced a result nor kept the block busy");

	// A result is only shown once the block has finished its work.
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy)
		else $error("result strobed while still busy");

	// The end of a melody stops playback and silences the buzzer.
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		sequence_done |-> valid && !playing && compare_value == 16'd0)
		else $error("sequence done without stopped, silent output");

	// The PWM timer is never switched off once running.
	a_timer_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		timer_enabled |=> timer_enabled)
		else $error("timer enable dropped");

endmodule

bind buzzer_melody_sequencer bms_chk u_bms_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.valid         (valid),
	.playing       (playing),
	.compare_value (compare_value),
	.timer_enabled (timer_enabled),
	.sequence_done (sequence_done)
);
